// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal holds while the output beat is stalled.
`define ASSERT_HOLD(lbl, sig, msg) \
  `ASSERT_CLK(lbl, out_valid_i && !out_ready_i |=> $stable(sig), msg)

`endif

// ----- hdl/mi3_pkg.sv -----
// Package: widths, mode codes, tables and payload types of the 3x3 inverse core.
`default_nettype none
package mi3_pkg;

  localparam int unsigned EW  = 16;  // input element, Q8.8
  localparam int unsigned RW  = 32;  // result element, Q16.16
  localparam int unsigned PW  = 32;  // 16x16 product
  localparam int unsigned CW  = 33;  // cofactor
  localparam int unsigned DTW = 49;  // exact determinant, Q24.24
  localparam int unsigned DNW = 49;  // divisor 2*|det|
  localparam int unsigned NMW = 57;  // dividend 2*|adj|*2^24 + |det|

  localparam logic [1:0] MODE_INV = 2'd0;
  localparam logic [1:0] MODE_ADJ = 2'd1;
  localparam logic [1:0] MODE_TRN = 2'd2;

  localparam logic [RW-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [RW-1:0] SAT_MIN = 32'h8000_0000;

  // Cofactor k = A[PA_X]*A[PA_Y] - A[PB_X]*A[PB_Y], sign folded in.
  localparam logic [3:0] PA_X [9] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam logic [3:0] PA_Y [9] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam logic [3:0] PB_X [9] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam logic [3:0] PB_Y [9] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};
  // Transposed index.
  localparam logic [3:0] TR   [9] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

  typedef struct packed {
    logic [DNW-1:0] rem;
    logic [RW-1:0]  nq;
    logic [DNW-1:0] den;
    logic           neg;
    logic           ovf;
    logic [RW-1:0]  alt;
  } lane_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic            det_zero;
    logic [RW-1:0]   det_r;
    lane_t [8:0]     lane;
  } front_t;

endpackage
`default_nettype wire

// ----- hdl/mi3_if.sv -----
// Valid/ready channel interfaces for matrix beats and result beats.
`default_nettype none
interface mi3_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic [1:0]         mode;
  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, mode,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, mode,
                  output ready);
endinterface

interface mi3_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [31:0] det;
  logic               singular;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, det, singular,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, det, singular,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/mi3_front.sv -----
// Front pipeline: minors, cofactors, determinant and divider setup, six stages.
`default_nettype none
module mi3_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  mi3_in_if.sink          in_i,
  output mi3_pkg::front_t front_o,
  output logic            front_valid_o,
  input  logic            front_ready_i
);
  import mi3_pkg::*;

  logic [5:0] v_q;
  logic [5:0] rdy;

  logic signed [EW-1:0]  ain    [9];
  logic signed [EW-1:0]  a0_q   [9];
  logic signed [EW-1:0]  a1_q   [9];
  logic signed [EW-1:0]  a2_q   [9];
  logic signed [EW-1:0]  a3_q   [9];
  logic signed [EW-1:0]  a4_q   [9];
  logic [1:0]            m0_q, m1_q, m2_q, m3_q, m4_q;
  logic signed [PW-1:0]  pa_q   [9];
  logic signed [PW-1:0]  pb_q   [9];
  logic signed [CW-1:0]  cof2_q [9];
  logic signed [CW-1:0]  cof3_q [9];
  logic signed [CW-1:0]  cof4_q [9];
  logic signed [DTW-1:0] dp_q   [3];
  logic signed [DTW-1:0] det4_q;
  front_t                prep;
  front_t                front_q;

  assign ain[0] = in_i.a00;
  assign ain[1] = in_i.a01;
  assign ain[2] = in_i.a02;
  assign ain[3] = in_i.a10;
  assign ain[4] = in_i.a11;
  assign ain[5] = in_i.a12;
  assign ain[6] = in_i.a20;
  assign ain[7] = in_i.a21;
  assign ain[8] = in_i.a22;

  for (genvar k = 0; k < 6; k++) begin : g_rdy
    assign rdy[k] = ~(&v_q[5:k]) | front_ready_i;
  end

  assign in_i.ready    = rdy[0];
  assign front_valid_o = v_q[5];
  assign front_o       = front_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Divider setup: magnitudes, overflow test, rounded determinant, non-divide results.
  always_comb begin
    logic              dneg;
    logic [47:0]       dabs;
    logic [DNW-1:0]    dden;
    logic [40:0]       dr;
    logic signed [CW-1:0] adj;
    logic [31:0]       aabs;
    logic [NMW-1:0]    num;
    dneg = det4_q[DTW-1];
    dabs = dneg ? 48'(-det4_q) : 48'(det4_q);
    dden = {dabs, 1'b0};
    dr   = 41'((49'(dabs) + 49'd128) >> 8);
    prep.mode     = m4_q;
    prep.det_zero = (det4_q == '0);
    if (!dneg) begin
      prep.det_r = (dr[40:31] != '0) ? SAT_MAX : {1'b0, dr[30:0]};
    end else begin
      prep.det_r = ((dr[40:32] != '0) || (dr[31] && (dr[30:0] != '0))) ? SAT_MIN
                                                                       : -dr[31:0];
    end
    for (int e = 0; e < 9; e++) begin
      adj  = cof4_q[TR[e]];
      aabs = adj[CW-1] ? 32'(-adj) : 32'(adj);
      num  = {aabs, 25'b0} + 57'(dabs);
      prep.lane[e].rem = 49'(num[56:32]);
      prep.lane[e].nq  = num[31:0];
      prep.lane[e].den = dden;
      prep.lane[e].neg = adj[CW-1] ^ dneg;
      prep.lane[e].ovf = (49'(num[56:32]) >= dden);
      case (m4_q)
        MODE_ADJ: begin
          if (adj[32] != adj[31]) prep.lane[e].alt = adj[32] ? SAT_MIN : SAT_MAX;
          else                    prep.lane[e].alt = adj[31:0];
        end
        MODE_TRN: prep.lane[e].alt = {{8{a4_q[TR[e]][EW-1]}}, a4_q[TR[e]], 8'h00};
        default:  prep.lane[e].alt = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_i.valid) begin
      a0_q <= ain;
      m0_q <= in_i.mode;
    end
    if (rdy[1] && v_q[0]) begin
      a1_q <= a0_q;
      m1_q <= m0_q;
      for (int e = 0; e < 9; e++) begin
        pa_q[e] <= a0_q[PA_X[e]] * a0_q[PA_Y[e]];
        pb_q[e] <= a0_q[PB_X[e]] * a0_q[PB_Y[e]];
      end
    end
    if (rdy[2] && v_q[1]) begin
      a2_q <= a1_q;
      m2_q <= m1_q;
      for (int e = 0; e < 9; e++) begin
        cof2_q[e] <= 33'(pa_q[e]) - 33'(pb_q[e]);
      end
    end
    if (rdy[3] && v_q[2]) begin
      a3_q   <= a2_q;
      m3_q   <= m2_q;
      cof3_q <= cof2_q;
      for (int c = 0; c < 3; c++) begin
        dp_q[c] <= a2_q[c] * cof2_q[c];
      end
    end
    if (rdy[4] && v_q[3]) begin
      a4_q   <= a3_q;
      m4_q   <= m3_q;
      cof4_q <= cof3_q;
      det4_q <= dp_q[0] + dp_q[1] + dp_q[2];
    end
    if (rdy[5] && v_q[4]) begin
      front_q <= prep;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mi3_div.sv -----
// Divider pipeline: one quotient bit per stage for nine lanes, then saturation and output register.
`default_nettype none
module mi3_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mi3_pkg::front_t front_i,
  input  logic            front_valid_i,
  output logic            front_ready_o,
  mi3_out_if.source       out_o
);
  import mi3_pkg::*;

  localparam int unsigned NS = RW;

  logic [NS:0]     v_q;
  logic [NS:0]     rdy;
  front_t          st_q [NS];
  logic [RW-1:0]   res  [9];
  logic [RW-1:0]   r_q  [9];
  logic [RW-1:0]   det_q;
  logic            sing_q;

  function automatic front_t step_all(front_t f);
    front_t o;
    logic [DNW:0] t;
    logic         ge;
    o = f;
    for (int e = 0; e < 9; e++) begin
      t  = {f.lane[e].rem, f.lane[e].nq[RW-1]};
      ge = (t >= {1'b0, f.lane[e].den});
      o.lane[e].rem = ge ? DNW'(t - {1'b0, f.lane[e].den}) : t[DNW-1:0];
      o.lane[e].nq  = {f.lane[e].nq[RW-2:0], ge};
    end
    return o;
  endfunction

  for (genvar k = 0; k <= NS; k++) begin : g_rdy
    assign rdy[k] = ~(&v_q[NS:k]) | out_o.ready;
  end

  assign front_ready_o = rdy[0];

  always_comb begin
    logic [RW-1:0] q;
    lane_t         l;
    for (int e = 0; e < 9; e++) begin
      l = st_q[NS-1].lane[e];
      q = l.nq;
      if (st_q[NS-1].mode == MODE_INV) begin
        if (st_q[NS-1].det_zero)  res[e] = '0;
        else if (!l.neg)          res[e] = (l.ovf || q[RW-1]) ? SAT_MAX : q;
        else if (l.ovf || (q[RW-1] && (q[RW-2:0] != '0))) res[e] = SAT_MIN;
        else                      res[e] = -q;
      end else begin
        res[e] = l.alt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= front_valid_i;
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && front_valid_i) st_q[0] <= step_all(front_i);
    for (int k = 1; k < NS; k++) begin
      if (rdy[k] && v_q[k-1]) st_q[k] <= step_all(st_q[k-1]);
    end
    if (rdy[NS] && v_q[NS-1]) begin
      r_q    <= res;
      det_q  <= st_q[NS-1].det_r;
      sing_q <= (st_q[NS-1].mode == MODE_INV) && st_q[NS-1].det_zero;
    end
  end

  assign out_o.valid    = v_q[NS];
  assign out_o.r00      = r_q[0];
  assign out_o.r01      = r_q[1];
  assign out_o.r02      = r_q[2];
  assign out_o.r10      = r_q[3];
  assign out_o.r11      = r_q[4];
  assign out_o.r12      = r_q[5];
  assign out_o.r20      = r_q[6];
  assign out_o.r21      = r_q[7];
  assign out_o.r22      = r_q[8];
  assign out_o.det      = det_q;
  assign out_o.singular = sing_q;

endmodule
`default_nettype wire

// ----- hdl/matrix3x3_inverse_core.sv -----
// Top level of the 3x3 matrix inverse / adjugate / transpose core.
// Usage:
//   in_i  : valid/ready beat with a 3x3 matrix of signed Q8.8 elements and a
//           mode (0 inverse, 1 adjugate, 2 transpose, 3 gives a zero matrix).
//   out_o : valid/ready beat with nine signed Q16.16 elements, the Q16.16
//           determinant and the singular flag, all saturated.
//   One result beat per input beat, in order.
//   Pipeline: 6 front stages, 32 divider stages with one quotient bit each
//   and 1 output register.
//   Throughput: one matrix per cycle while the output is not stalled; every
//   stage of the divider holds its own item.
//   Reset (rst_ni low, async) empties the pipeline; no result is shown after.
//   When out_o.ready is low, the output beat holds and stages behind it keep
//   filling bubbles; in_i.ready drops only once every stage is occupied.
`default_nettype none
module matrix3x3_inverse_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mi3_in_if.sink    in_i,
  mi3_out_if.source out_o
);
  import mi3_pkg::*;

  front_t front;
  logic   front_valid;
  logic   front_ready;

  mi3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .front_o       (front),
    .front_valid_o (front_valid),
    .front_ready_i (front_ready)
  );

  mi3_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .front_i       (front),
    .front_valid_i (front_valid),
    .front_ready_o (front_ready),
    .out_o         (out_o)
  );

endmodule
`default_nettype wire

// ----- hdl/mi3_checker.sv -----
// Port checker for the 3x3 inverse core and its bind.
`default_nettype none
`include "assert_macros.svh"
module mi3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] r00_i,
  input logic [31:0] r11_i,
  input logic [31:0] r22_i,
  input logic [31:0] det_i,
  input logic        singular_i
);

  `ASSERT_CLK(a_valid_hold, out_valid_i && !out_ready_i |=> out_valid_i, "output beat dropped")
  `ASSERT_HOLD(a_det_hold, det_i, "det changed during stall")
  `ASSERT_CLK(a_sing_det, out_valid_i && singular_i |-> det_i == '0, "singular with nonzero det")
  `ASSERT_CLK(a_sing_zero, out_valid_i && singular_i |-> r00_i == '0 && r11_i == '0 && r22_i == '0, "singular result not zeroed")

endmodule

bind matrix3x3_inverse_core mi3_checker u_mi3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .r00_i       (out_o.r00),
  .r11_i       (out_o.r11),
  .r22_i       (out_o.r22),
  .det_i       (out_o.det),
  .singular_i  (out_o.singular)
);
`default_nettype wire
